FILE: src/brfc_pkg.sv
// ----------------------------------------------------------------------------
// brfc_pkg
// Shared constants, types and color helpers for the bilinear rectangle fill.
// ----------------------------------------------------------------------------
package brfc_pkg;

  localparam int MAX_SIDE  = 4096;
  localparam int DEN_W     = $clog2(MAX_SIDE + 1);
  localparam int REM_W     = DEN_W + 1;
  localparam int COORD_W   = 12;
  localparam int PIX_W     = 13;
  localparam int SIZE_W    = 13;
  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int FRAC_BITS = 10;
  localparam int DIV_STEP  = 2;
  localparam int DIV_STAGES = FRAC_BITS / DIV_STEP;
  // input reg + divider stages + side-color stage + output stage
  localparam int PIPE_LATENCY = DIV_STAGES + 3;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  typedef enum logic [2:0] {
    REG_CORNER_TL,
    REG_CORNER_TR,
    REG_CORNER_BL,
    REG_CORNER_BR,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_ORIGIN_X,
    REG_ORIGIN_Y
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             in_rect;
    logic             col_first;
    logic             col_last;
    logic             mid_row;
  } ctl_t;

  // (a*(1-k) + b*k) in fixed point, truncated
  function automatic logic [CHAN_W-1:0] mix_byte(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b,
                                                 input logic [FRAC_BITS-1:0] k);
    logic [FRAC_BITS:0]             kc;
    logic [FRAC_BITS+CHAN_W:0]      acc;
    kc  = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, k};
    acc = (FRAC_BITS+CHAN_W+1)'(a) * (FRAC_BITS+CHAN_W+1)'(kc)
        + (FRAC_BITS+CHAN_W+1)'(b) * (FRAC_BITS+CHAN_W+1)'(k);
    return acc[FRAC_BITS+CHAN_W-1:FRAC_BITS];
  endfunction

  function automatic logic [COLOR_W-1:0] mix_color(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b,
                                                   input logic [FRAC_BITS-1:0] k);
    logic [COLOR_W-1:0] r;
    r = '0;
    for (int ch = 0; ch < COLOR_W / CHAN_W; ch++) begin
      r[ch*CHAN_W +: CHAN_W] = mix_byte(a[ch*CHAN_W +: CHAN_W], b[ch*CHAN_W +: CHAN_W], k);
    end
    return r;
  endfunction

endpackage

FILE: src/bilinear_rect_fill_core.sv
// ----------------------------------------------------------------------------
// bilinear_rect_fill_core
// Bilinear fill of a rectangle from four corner colors, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Program the corners, rectangle size and origin over the APB port while
//   the pipe is empty. Then present (in_col, in_row) with start high; a beat
//   is taken on every edge where start is high and busy is low.
//   Each beat passes the input register and the stages named below, then
//   yields one result beat, marked by a one-cycle out_strobe, carrying the
//   absolute pixel address, three color channels and out_write_enable.
//   Throughput is one pixel per clock out of reset: each weight division
//   runs in its own 5-stage restoring divider (2 quotient bits per stage),
//   followed by one stage for the side colors and one for the final blend.
//   There is no back pressure: results are shown once and must be taken.
//   Reset (rst_n low, synchronous) empties the pipe, holds busy high and
//   restores the register defaults (size 1x1, all else zero); busy drops
//   in the cycle after reset is released.
// ----------------------------------------------------------------------------
module bilinear_rect_fill_core
  import brfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // input channel
  input  logic                start,
  output logic                busy,
  input  logic [COORD_W-1:0]  in_col,
  input  logic [COORD_W-1:0]  in_row,
  // result channel
  output logic                out_strobe,
  output logic [PIX_W-1:0]    out_pixel_x,
  output logic [PIX_W-1:0]    out_pixel_y,
  output logic [CHAN_W-1:0]   out_chan0,
  output logic [CHAN_W-1:0]   out_chan1,
  output logic [CHAN_W-1:0]   out_chan2,
  output logic                out_write_enable
);

  // ---------------- configuration registers ----------------
  logic [COLOR_W-1:0] corner_tl_r, corner_tr_r, corner_bl_r, corner_br_r;
  logic [SIZE_W-1:0]  rect_width_r, rect_height_r;
  logic [COORD_W-1:0] origin_x_r, origin_y_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_tl_r   <= '0;
      corner_tr_r   <= '0;
      corner_bl_r   <= '0;
      corner_br_r   <= '0;
      rect_width_r  <= SIZE_W'(1);
      rect_height_r <= SIZE_W'(1);
      origin_x_r    <= '0;
      origin_y_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CORNER_TL:   corner_tl_r   <= pwdata[COLOR_W-1:0];
        REG_CORNER_TR:   corner_tr_r   <= pwdata[COLOR_W-1:0];
        REG_CORNER_BL:   corner_bl_r   <= pwdata[COLOR_W-1:0];
        REG_CORNER_BR:   corner_br_r   <= pwdata[COLOR_W-1:0];
        REG_RECT_WIDTH:  rect_width_r  <= pwdata[SIZE_W-1:0];
        REG_RECT_HEIGHT: rect_height_r <= pwdata[SIZE_W-1:0];
        REG_ORIGIN_X:    origin_x_r    <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:    origin_y_r    <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CORNER_TL:   prdata = DATA_W'(corner_tl_r);
      REG_CORNER_TR:   prdata = DATA_W'(corner_tr_r);
      REG_CORNER_BL:   prdata = DATA_W'(corner_bl_r);
      REG_CORNER_BR:   prdata = DATA_W'(corner_br_r);
      REG_RECT_WIDTH:  prdata = DATA_W'(rect_width_r);
      REG_RECT_HEIGHT: prdata = DATA_W'(rect_height_r);
      REG_ORIGIN_X:    prdata = DATA_W'(origin_x_r);
      REG_ORIGIN_Y:    prdata = DATA_W'(origin_y_r);
      default:         prdata = '0;
    endcase
  end

  // saturate size to MAX_SIDE
  logic [DEN_W-1:0] side_w, side_h;

  always_comb begin
    if (32'(rect_width_r) > 32'(MAX_SIDE)) side_w = DEN_W'(MAX_SIDE);
    else                                   side_w = DEN_W'(rect_width_r);
    if (32'(rect_height_r) > 32'(MAX_SIDE)) side_h = DEN_W'(MAX_SIDE);
    else                                    side_h = DEN_W'(rect_height_r);
  end

  // ---------------- stage A: input register ----------------
  logic               busy_r;
  logic               accept;
  logic               a_vld_r;
  logic [COORD_W-1:0] a_col_r, a_row_r;

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      a_vld_r <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      a_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_col_r <= in_col;
      a_row_r <= in_row;
    end
  end

  ctl_t             a_ctl;
  logic [DEN_W-1:0] a_num_col, a_num_row;

  always_comb begin
    a_ctl.px        = PIX_W'(origin_x_r) + PIX_W'(a_col_r);
    a_ctl.py        = PIX_W'(origin_y_r) + PIX_W'(a_row_r);
    a_ctl.in_rect   = (32'(a_col_r) < 32'(side_w)) && (32'(a_row_r) < 32'(side_h));
    a_ctl.col_first = (a_col_r == '0);
    a_ctl.col_last  = ((32'(a_col_r) + 32'd1) == 32'(side_w));
    a_ctl.mid_row   = (a_row_r != '0) && ((32'(a_row_r) + 32'd1) < 32'(side_h));
    // numerators forced to zero outside, so the dividers see num >= den only for a zero side
    a_num_col = a_ctl.in_rect ? DEN_W'(a_col_r) : '0;
    a_num_row = a_ctl.in_rect ? DEN_W'(a_row_r) : '0;
  end

  // ---------------- weight dividers ----------------
  logic [FRAC_BITS-1:0] wc_q, wr_q;

  brfc_div u_div_col (
    .clk (clk),
    .num (a_num_col),
    .den (side_w),
    .quo (wc_q)
  );

  brfc_div u_div_row (
    .clk (clk),
    .num (a_num_row),
    .den (side_h),
    .quo (wr_q)
  );

  // control travels alongside the divider stages
  logic [DIV_STAGES-1:0] vld_r;
  ctl_t                  ctl_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STAGES-2:0], a_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0] <= a_ctl;
    for (int i = 1; i < DIV_STAGES; i++) begin
      ctl_r[i] <= ctl_r[i-1];
    end
  end

  // ---------------- stage B: side colors ----------------
  logic                 b_vld_r;
  ctl_t                 b_ctl_r;
  logic [COLOR_W-1:0]   b_left_r, b_right_r;
  logic [FRAC_BITS-1:0] b_wc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    b_ctl_r   <= ctl_r[DIV_STAGES-1];
    b_left_r  <= mix_color(corner_tl_r, corner_bl_r, wr_q);
    b_right_r <= mix_color(corner_tr_r, corner_br_r, wr_q);
    b_wc_r    <= wc_q;
  end

  // ---------------- stage C: blend and output ----------------
  logic [COLOR_W-1:0] c_color;
  logic               c_we;

  always_comb begin
    c_color = '0;
    c_we    = 1'b0;
    if (b_ctl_r.in_rect) begin
      // width one: the last-column case wins over the first
      if (b_ctl_r.col_last) begin
        c_color = b_right_r;
        c_we    = b_ctl_r.mid_row;
      end else if (b_ctl_r.col_first) begin
        c_color = b_left_r;
        c_we    = b_ctl_r.mid_row;
      end else begin
        c_color = mix_color(b_left_r, b_right_r, b_wc_r);
        c_we    = 1'b1;
      end
    end
  end

  logic              out_strobe_r;
  logic [PIX_W-1:0]  out_pixel_x_r, out_pixel_y_r;
  logic [CHAN_W-1:0] out_chan0_r, out_chan1_r, out_chan2_r;
  logic              out_write_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_x_r      <= b_ctl_r.px;
    out_pixel_y_r      <= b_ctl_r.py;
    out_chan0_r        <= c_color[0*CHAN_W +: CHAN_W];
    out_chan1_r        <= c_color[1*CHAN_W +: CHAN_W];
    out_chan2_r        <= c_color[2*CHAN_W +: CHAN_W];
    out_write_enable_r <= c_we;
  end

  assign out_strobe       = out_strobe_r;
  assign out_pixel_x      = out_pixel_x_r;
  assign out_pixel_y      = out_pixel_y_r;
  assign out_chan0        = out_chan0_r;
  assign out_chan1        = out_chan1_r;
  assign out_chan2        = out_chan2_r;
  assign out_write_enable = out_write_enable_r;

endmodule

FILE: src/brfc_div.sv
// ----------------------------------------------------------------------------
// brfc_div
// Pipelined fractional divider: quo = num * 2^FRAC_BITS / den, for num < den.
// Restoring division, DIV_STEP quotient bits per register stage.
// ----------------------------------------------------------------------------
module brfc_div
  import brfc_pkg::*;
(
  input  logic                 clk,
  input  logic [DEN_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic [FRAC_BITS-1:0] quo
);

  logic [REM_W-1:0]     rem_r [DIV_STAGES-1];
  logic [FRAC_BITS-1:0] q_r   [DIV_STAGES];

  genvar s;
  for (s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [REM_W-1:0]     rem_src;
    logic [REM_W-1:0]     rem_nxt;
    logic [FRAC_BITS-1:0] q_src;
    logic [FRAC_BITS-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign rem_src = REM_W'(num);
      assign q_src   = '0;
    end else begin : g_rest
      assign rem_src = rem_r[s-1];
      assign q_src   = q_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_src;
      q_nxt   = q_src;
      for (int b = 0; b < DIV_STEP; b++) begin
        // remainder stays below den, so the shifted value fits in REM_W
        rem_nxt = {rem_nxt[REM_W-2:0], 1'b0};
        q_nxt   = {q_nxt[FRAC_BITS-2:0], 1'b0};
        if (rem_nxt >= REM_W'(den)) begin
          rem_nxt  = rem_nxt - REM_W'(den);
          q_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      q_r[s] <= q_nxt;
    end

    if (s < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

FILE: src/brfc_checker.sv
// ----------------------------------------------------------------------------
// brfc_checker
// Port-level checks of the fill core: reset behavior and fixed latency.
// ----------------------------------------------------------------------------
module brfc_checker
  import brfc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // busy is raised by reset
  a_busy_in_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy not raised after reset");

  // once out of reset busy stays low, so the core can take a beat every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  // every accepted beat returns as a result beat on out_strobe
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_strobe)
    else $error("result beat missing");

  // no result beat without an accepted beat behind it
  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result beat without input beat");

endmodule

bind bilinear_rect_fill_core brfc_checker u_brfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bilinear_rect_fill_core. Rectangle setups go in over
// APB and are read back. Pixel beats are then sent with random gaps, and each
// result beat is checked against the directed table or a local model of the
// bilinear fill. The run starts with that table, then random rectangle setups.
// ----------------------------------------------------------------------------
module testbench;
  import brfc_pkg::*;

  localparam int NUM_SETUPS      = 12;
  localparam int PIXELS_PER_SETUP = 86;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [CHAN_W-1:0] c0;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c2;
    logic              we;
  } pixel_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    reg_idx_t           idx;
    logic [DATA_W-1:0]  data;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               known;
    pixel_t             exp;
  } step_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic [COORD_W-1:0]  in_col;
  logic [COORD_W-1:0]  in_row;
  logic                out_strobe;
  logic [PIX_W-1:0]    out_pixel_x;
  logic [PIX_W-1:0]    out_pixel_y;
  logic [CHAN_W-1:0]   out_chan0;
  logic [CHAN_W-1:0]   out_chan1;
  logic [CHAN_W-1:0]   out_chan2;
  logic                out_write_enable;

  bilinear_rect_fill_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_col           (in_col),
    .in_row           (in_row),
    .out_strobe       (out_strobe),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_chan0        (out_chan0),
    .out_chan1        (out_chan1),
    .out_chan2        (out_chan2),
    .out_write_enable (out_write_enable)
  );

  // shadow copy of the register file, masked to each register's width
  logic [DATA_W-1:0] shadow [8];
  pixel_t            expected_pixels[$];
  step_t             plan[$];
  int                err_count;
  int                n_pixels_sent;
  int                n_pixels_seen;
  int                n_written;
  int                n_setups;
  logic              steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("[bilinear_rect_fill_core] ERROR");
    $finish;
  end

  function automatic logic [DATA_W-1:0] reg_mask(input reg_idx_t idx);
    case (idx)
      REG_RECT_WIDTH, REG_RECT_HEIGHT: return (1 << SIZE_W) - 1;
      REG_ORIGIN_X, REG_ORIGIN_Y:      return (1 << COORD_W) - 1;
      default:                         return (1 << COLOR_W) - 1;
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] blend_chan(input int unsigned a, b, k);
    return CHAN_W'((a * ((1 << FRAC_BITS) - k) + b * k) >> FRAC_BITS);
  endfunction

  function automatic logic [COLOR_W-1:0] blend_rgb(input logic [COLOR_W-1:0] a, b,
                                                   input int unsigned k);
    logic [COLOR_W-1:0] r;
    for (int ch = 0; ch < 3; ch++) begin
      r[ch*CHAN_W +: CHAN_W] = blend_chan(a[ch*CHAN_W +: CHAN_W], b[ch*CHAN_W +: CHAN_W], k);
    end
    return r;
  endfunction

  function automatic pixel_t interp_pixel(input logic [COORD_W-1:0] col, row);
    int unsigned        w, h, c, r, wr;
    logic [COLOR_W-1:0] left, right, rgb;
    logic               we;
    pixel_t             p;
    w = shadow[REG_RECT_WIDTH];
    h = shadow[REG_RECT_HEIGHT];
    if (w > MAX_SIDE) w = MAX_SIDE;
    if (h > MAX_SIDE) h = MAX_SIDE;
    c = col;
    r = row;
    rgb = '0;
    we = 1'b0;
    if (w != 0 && h != 0 && c < w && r < h) begin
      wr = (r << FRAC_BITS) / h;
      left  = blend_rgb(shadow[REG_CORNER_TL][COLOR_W-1:0],
                        shadow[REG_CORNER_BL][COLOR_W-1:0], wr);
      right = blend_rgb(shadow[REG_CORNER_TR][COLOR_W-1:0],
                        shadow[REG_CORNER_BR][COLOR_W-1:0], wr);
      // right side wins when the rectangle is one column wide
      if (c + 1 == w) begin
        rgb = right;
        we  = (r > 0 && r + 1 < h);
      end else if (c == 0) begin
        rgb = left;
        we  = (r > 0 && r + 1 < h);
      end else begin
        rgb = blend_rgb(left, right, (c << FRAC_BITS) / w);
        we  = 1'b1;
      end
    end
    p.x  = PIX_W'(shadow[REG_ORIGIN_X] + c);
    p.y  = PIX_W'(shadow[REG_ORIGIN_Y] + r);
    p.c0 = rgb[7:0];
    p.c1 = rgb[15:8];
    p.c2 = rgb[23:16];
    p.we = we;
    return p;
  endfunction

  function automatic pixel_t mk_pixel(input int x, y, input logic [COLOR_W-1:0] rgb,
                                      input logic we);
    pixel_t p;
    p.x  = PIX_W'(x);
    p.y  = PIX_W'(y);
    p.c0 = rgb[7:0];
    p.c1 = rgb[15:8];
    p.c2 = rgb[23:16];
    p.we = we;
    return p;
  endfunction

  function automatic step_t wr_step(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t px_step(input int col, row);
    step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.col  = COORD_W'(col);
    s.row  = COORD_W'(row);
    return s;
  endfunction

  function automatic step_t px_step_known(input int col, row, input pixel_t exp);
    step_t s;
    s = px_step(col, row);
    s.known = 1'b1;
    s.exp   = exp;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one APB transfer, then back to idle
  task automatic apb_access(input logic wr, input reg_idx_t idx,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] rd;
    m = reg_mask(idx);
    // junk in the unused upper bits must be dropped
    apb_access(1'b1, idx, (val & m) | ($urandom & ~m), rd);
    shadow[idx] = val & m;
    apb_access(1'b0, idx, $urandom, rd);
    if (rd !== shadow[idx])
      report_mismatch($sformatf("readback %s exp %h got %h", idx.name(), shadow[idx], rd));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] col, row, input logic known,
                            input pixel_t typed);
    int gap;
    start  <= 1'b1;
    in_col <= col;
    in_row <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_pixels.push_back(known ? typed : interp_pixel(col, row));
    n_pixels_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_side();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return MAX_SIDE;
      4:       return $urandom_range(MAX_SIDE + 1, (1 << SIZE_W) - 1);
      5, 6:    return $urandom_range(3, MAX_SIDE - 1);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_corner();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic int pick_origin();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return (1 << COORD_W) - 1;
      default: return $urandom_range(0, (1 << COORD_W) - 1);
    endcase
  endfunction

  task automatic random_setup();
    cfg_write(REG_CORNER_TL, pick_corner());
    cfg_write(REG_CORNER_TR, pick_corner());
    cfg_write(REG_CORNER_BL, pick_corner());
    cfg_write(REG_CORNER_BR, pick_corner());
    cfg_write(REG_RECT_WIDTH, pick_side());
    cfg_write(REG_RECT_HEIGHT, pick_side());
    cfg_write(REG_ORIGIN_X, pick_origin());
    cfg_write(REG_ORIGIN_Y, pick_origin());
    n_setups++;
  endtask

  // mostly positions inside the rectangle, biased to its edges, some noise
  task automatic pick_pixel(output logic [COORD_W-1:0] col, row);
    int unsigned w, h;
    int          mode;
    w = shadow[REG_RECT_WIDTH];
    h = shadow[REG_RECT_HEIGHT];
    if (w > MAX_SIDE) w = MAX_SIDE;
    if (h > MAX_SIDE) h = MAX_SIDE;
    mode = $urandom_range(0, 9);
    if (w == 0 || h == 0 || mode < 2) begin
      col = COORD_W'($urandom);
      row = COORD_W'($urandom);
    end else begin
      col = COORD_W'($urandom_range(0, w - 1));
      row = COORD_W'($urandom_range(0, h - 1));
      if (mode == 2) col = $urandom_range(0, 1) ? COORD_W'(w - 1) : '0;
      if (mode == 3) row = $urandom_range(0, 1) ? COORD_W'(h - 1) : '0;
    end
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_strobe) begin
      n_pixels_seen++;
      if (out_write_enable) n_written++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected beat at (%0d,%0d)", out_pixel_x, out_pixel_y));
      end else begin
        e = expected_pixels.pop_front();
        if (out_pixel_x !== e.x || out_pixel_y !== e.y || out_chan0 !== e.c0 ||
            out_chan1 !== e.c1 || out_chan2 !== e.c2 || out_write_enable !== e.we)
          report_mismatch($sformatf(
            "exp x=%0d y=%0d rgb=%h_%h_%h we=%b got x=%0d y=%0d rgb=%h_%h_%h we=%b",
            e.x, e.y, e.c2, e.c1, e.c0, e.we, out_pixel_x, out_pixel_y,
            out_chan2, out_chan1, out_chan0, out_write_enable));
      end
    end
  end

  initial begin
    logic [COORD_W-1:0] col, row;
    err_count     = 0;
    n_pixels_sent = 0;
    n_pixels_seen = 0;
    n_written     = 0;
    n_setups      = 0;
    steady        = 1'b0;
    foreach (shadow[i]) shadow[i] = '0;
    shadow[REG_RECT_WIDTH]  = 1;
    shadow[REG_RECT_HEIGHT] = 1;

    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    start   <= 1'b0;
    in_col  <= '0;
    in_row  <= '0;

    // defaults after reset: 1x1 black rectangle at the image origin
    plan.push_back(px_step_known(0, 0, mk_pixel(0, 0, 24'h000000, 1'b0)));
    plan.push_back(px_step_known(4095, 4095, mk_pixel(4095, 4095, 24'h000000, 1'b0)));
    // 4x4 at the far corner of the image; addresses carry past 12 bits
    plan.push_back(wr_step(REG_CORNER_TL, 32'h0010_2030));
    plan.push_back(wr_step(REG_CORNER_TR, 32'h00FF_FFFF));
    plan.push_back(wr_step(REG_CORNER_BL, 32'h0000_0000));
    plan.push_back(wr_step(REG_CORNER_BR, 32'h0080_FF01));
    plan.push_back(wr_step(REG_RECT_WIDTH, 4));
    plan.push_back(wr_step(REG_RECT_HEIGHT, 4));
    plan.push_back(wr_step(REG_ORIGIN_X, 4095));
    plan.push_back(wr_step(REG_ORIGIN_Y, 4095));
    plan.push_back(px_step_known(0, 0, mk_pixel(4095, 4095, 24'h102030, 1'b0)));
    plan.push_back(px_step_known(3, 0, mk_pixel(4098, 4095, 24'hFFFFFF, 1'b0)));
    plan.push_back(px_step(0, 3));
    plan.push_back(px_step(3, 3));
    plan.push_back(px_step(1, 1));
    plan.push_back(px_step(0, 1));
    plan.push_back(px_step(3, 2));
    plan.push_back(px_step(2, 3));
    plan.push_back(px_step_known(4, 0, mk_pixel(4099, 4095, 24'h000000, 1'b0)));
    plan.push_back(px_step_known(0, 4, mk_pixel(4095, 4099, 24'h000000, 1'b0)));
    plan.push_back(px_step_known(4095, 4095, mk_pixel(8190, 8190, 24'h000000, 1'b0)));
    // one column wide, height beyond the limit saturates
    plan.push_back(wr_step(REG_RECT_WIDTH, 1));
    plan.push_back(wr_step(REG_RECT_HEIGHT, 8191));
    plan.push_back(wr_step(REG_ORIGIN_X, 0));
    plan.push_back(wr_step(REG_ORIGIN_Y, 0));
    plan.push_back(px_step_known(0, 0, mk_pixel(0, 0, 24'hFFFFFF, 1'b0)));
    plan.push_back(px_step(0, 2048));
    plan.push_back(px_step(0, 4095));
    // zero width: everything is outside
    plan.push_back(wr_step(REG_RECT_WIDTH, 0));
    plan.push_back(wr_step(REG_RECT_HEIGHT, 5));
    plan.push_back(px_step_known(0, 0, mk_pixel(0, 0, 24'h000000, 1'b0)));
    // full width, two rows: both rows are edge rows
    plan.push_back(wr_step(REG_RECT_WIDTH, MAX_SIDE));
    plan.push_back(wr_step(REG_RECT_HEIGHT, 2));
    plan.push_back(wr_step(REG_ORIGIN_X, 123));
    plan.push_back(px_step(2048, 0));
    plan.push_back(px_step(4095, 1));
    plan.push_back(px_step(0, 1));
    // oversize width with zero height
    plan.push_back(wr_step(REG_RECT_WIDTH, 5000));
    plan.push_back(wr_step(REG_RECT_HEIGHT, 0));
    plan.push_back(px_step_known(5, 5, mk_pixel(128, 5, 24'h000000, 1'b0)));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        wait_idle();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].col, plan[i].row, plan[i].known, plan[i].exp);
      end
    end

    for (int s = 0; s < NUM_SETUPS; s++) begin
      wait_idle();
      random_setup();
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PIXELS_PER_SETUP; i++) begin
        // now and then let the pipe run dry mid-setup
        if ($urandom_range(0, 63) == 0) wait_idle();
        pick_pixel(col, row);
        send_pixel(col, row, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    $display("%0d pixel beats sent, %0d results checked, %0d written", n_pixels_sent,
             n_pixels_seen, n_written);
    $display("%0d random rectangle setups after the directed table, %0d mismatches",
             n_setups, err_count);
    if (err_count == 0) begin
      $display("[bilinear_rect_fill_core] OK");
    end else begin
      $display("[bilinear_rect_fill_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: bilinear_rect_fill_core.f
src/brfc_pkg.sv
src/brfc_div.sv
src/bilinear_rect_fill_core.sv
src/brfc_checker.sv
dv/testbench.sv
